>>> design/bcd_adj_pkg.sv
// shared types, command codes and helpers for the bcd/ascii adjust unit
package bcd_adj_pkg;

  localparam int CmdWidth = 3;

  localparam logic [CmdWidth-1:0] CMD_AAA = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_AAS = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_AAM = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_AAD = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_DAA = 3'd4;
  localparam logic [CmdWidth-1:0] CMD_DAS = 3'd5;

  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] ADJ_LOW     = 8'h06;
  localparam logic [7:0] ADJ_HIGH    = 8'h60;
  localparam logic [7:0] BCD_MAX     = 8'h99;

  // one restoring divide step result
  typedef struct packed {
    logic [7:0] rem;
    logic       qbit;
  } div_step_t;

  // operands and partial results carried through the front stages
  typedef struct packed {
    logic [CmdWidth-1:0] cmd;
    logic [15:0]         ax;
    logic [7:0]          imm;
    logic                cf;
    logic                af;
    logic [15:0]         adj_ax;
    logic                adj_cf;
    logic                adj_af;
    logic [7:0]          prod;
    logic [7:0]          rem;
    logic [7:0]          quo;
  } front_t;

  // final register values before flag generation
  typedef struct packed {
    logic [15:0] ax;
    logic        cf;
    logic        af;
    logic        set_szp;
    logic        derr;
  } result_t;

  // shift in one dividend bit, subtract divisor when it fits
  function automatic div_step_t div_step(input logic [7:0] rem, input logic dbit,
                                         input logic [7:0] divisor);
    div_step_t  res;
    logic [8:0] trial;
    trial = {rem, dbit};
    if (trial >= {1'b0, divisor}) begin
      res.rem  = 8'(trial - {1'b0, divisor});
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[7:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

>>> design/bcd_ascii_adjust_unit.sv
// top level of the bcd/ascii adjust unit: four stage pipeline
//
// executes the 8086 decimal and ascii adjust operations aaa, aas, aam, aad,
// daa and das on a 16-bit accumulator value with its carry and aux flags
// input channel: in_valid / in_stall with command, ax_in, imm, carry_in,
//   aux_in; a transaction completes when in_valid is high and in_stall low
// output channel: out_valid / out_stall with ax_out, the new flags and
//   divide_error; every input transaction yields exactly one output one
// timing: out_valid rises once the accepted item has passed registers a, b,
//   c and the output register; throughput is one transaction per cycle
//   while no stalled result is held; stage a holds the aad multiply
//   and the first three divide steps for aam (8 restoring steps over 3 stages)
// when out_stall holds a valid result the whole pipeline freezes and
//   in_stall rises in the same cycle, so nothing is dropped or repeated
// rst is synchronous and active high; it clears all stage valid bits,
//   payload registers are left as they are
// aam with a zero immediate reports divide_error and passes ax and flags
//   through; zero, sign and parity then read as 0
module bcd_ascii_adjust_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [15:0] ax_in,
  input  logic [7:0]  imm,
  input  logic        carry_in,
  input  logic        aux_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] ax_out,
  output logic        carry_out,
  output logic        aux_out,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        parity_flag,
  output logic        divide_error
);

  // global advance: every stage moves unless a held result waits
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // ---------------------------------------------------------------------
  // stage a: decode, bcd adjust, aad multiply, divide steps 7..5
  // ---------------------------------------------------------------------
  bcd_adj_pkg::front_t    a_next;
  bcd_adj_pkg::front_t    a_reg;
  logic                   valid_a;
  logic [7:0]             al_in;
  logic [7:0]             ah_in;
  logic                   low_adj;
  logic                   high_adj;
  logic [7:0]             al_low;
  logic [15:0]            prod_full;
  bcd_adj_pkg::div_step_t step_a [3];

  always_comb begin
    al_in    = ax_in[7:0];
    ah_in    = ax_in[15:8];
    low_adj  = (al_in[3:0] > bcd_adj_pkg::DIGIT_MAX) || aux_in;
    high_adj = (al_in > bcd_adj_pkg::BCD_MAX) || carry_in;
    al_low   = al_in;

    a_next.cmd    = command;
    a_next.ax     = ax_in;
    a_next.imm    = imm;
    a_next.cf     = carry_in;
    a_next.af     = aux_in;
    a_next.adj_ax = ax_in;
    a_next.adj_cf = carry_in;
    a_next.adj_af = aux_in;

    unique case (command)
      bcd_adj_pkg::CMD_AAA: begin
        // no carry from al into ah in the 8086 form
        al_low = low_adj ? 8'(al_in + bcd_adj_pkg::ADJ_LOW) : al_in;
        a_next.adj_ax = {(low_adj ? 8'(ah_in + 8'd1) : ah_in),
                         al_low & bcd_adj_pkg::NIBBLE_MASK};
        a_next.adj_cf = low_adj;
        a_next.adj_af = low_adj;
      end
      bcd_adj_pkg::CMD_AAS: begin
        al_low = low_adj ? 8'(al_in - bcd_adj_pkg::ADJ_LOW) : al_in;
        a_next.adj_ax = {(low_adj ? 8'(ah_in - 8'd1) : ah_in),
                         al_low & bcd_adj_pkg::NIBBLE_MASK};
        a_next.adj_cf = low_adj;
        a_next.adj_af = low_adj;
      end
      bcd_adj_pkg::CMD_DAA: begin
        // high test uses the original al and carry
        al_low = low_adj ? 8'(al_in + bcd_adj_pkg::ADJ_LOW) : al_in;
        a_next.adj_ax = {ah_in, (high_adj ? 8'(al_low + bcd_adj_pkg::ADJ_HIGH)
                                          : al_low)};
        a_next.adj_cf = high_adj;
        a_next.adj_af = low_adj;
      end
      bcd_adj_pkg::CMD_DAS: begin
        al_low = low_adj ? 8'(al_in - bcd_adj_pkg::ADJ_LOW) : al_in;
        a_next.adj_ax = {ah_in, (high_adj ? 8'(al_low - bcd_adj_pkg::ADJ_HIGH)
                                          : al_low)};
        a_next.adj_cf = high_adj;
        a_next.adj_af = low_adj;
      end
      default: begin
        a_next.adj_ax = ax_in;
      end
    endcase

    // aad: only the low byte of ah * imm matters
    prod_full   = ah_in * imm;
    a_next.prod = prod_full[7:0];

    // aam: first three restoring steps on al / imm
    step_a[0]  = bcd_adj_pkg::div_step(8'h00, al_in[7], imm);
    step_a[1]  = bcd_adj_pkg::div_step(step_a[0].rem, al_in[6], imm);
    step_a[2]  = bcd_adj_pkg::div_step(step_a[1].rem, al_in[5], imm);
    a_next.rem = step_a[2].rem;
    a_next.quo = {5'b00000, step_a[0].qbit, step_a[1].qbit, step_a[2].qbit};
  end

  // ---------------------------------------------------------------------
  // stage b: divide steps 4..2
  // ---------------------------------------------------------------------
  bcd_adj_pkg::front_t    b_next;
  bcd_adj_pkg::front_t    b_reg;
  logic                   valid_b;
  bcd_adj_pkg::div_step_t step_b [3];

  always_comb begin
    b_next     = a_reg;
    step_b[0]  = bcd_adj_pkg::div_step(a_reg.rem, a_reg.ax[4], a_reg.imm);
    step_b[1]  = bcd_adj_pkg::div_step(step_b[0].rem, a_reg.ax[3], a_reg.imm);
    step_b[2]  = bcd_adj_pkg::div_step(step_b[1].rem, a_reg.ax[2], a_reg.imm);
    b_next.rem = step_b[2].rem;
    b_next.quo = {a_reg.quo[4:0], step_b[0].qbit, step_b[1].qbit, step_b[2].qbit};
  end

  // ---------------------------------------------------------------------
  // stage c: divide steps 1..0, aad add, pick the result per command
  // ---------------------------------------------------------------------
  bcd_adj_pkg::result_t   c_next;
  bcd_adj_pkg::result_t   c_reg;
  logic                   valid_c;
  bcd_adj_pkg::div_step_t step_c [2];
  logic [7:0]             quo_final;

  always_comb begin
    step_c[0] = bcd_adj_pkg::div_step(b_reg.rem, b_reg.ax[1], b_reg.imm);
    step_c[1] = bcd_adj_pkg::div_step(step_c[0].rem, b_reg.ax[0], b_reg.imm);
    quo_final = {b_reg.quo[5:0], step_c[0].qbit, step_c[1].qbit};

    c_next.ax      = b_reg.ax;
    c_next.cf      = b_reg.cf;
    c_next.af      = b_reg.af;
    c_next.set_szp = 1'b1;
    c_next.derr    = 1'b0;

    unique case (b_reg.cmd) inside
      bcd_adj_pkg::CMD_AAM: begin
        if (b_reg.imm == 8'h00) begin
          c_next.derr    = 1'b1;
          c_next.set_szp = 1'b0;
        end else begin
          c_next.ax = {quo_final, step_c[1].rem};
        end
      end
      bcd_adj_pkg::CMD_AAD: begin
        c_next.ax = {8'h00, 8'(b_reg.ax[7:0] + b_reg.prod)};
      end
      bcd_adj_pkg::CMD_AAA, bcd_adj_pkg::CMD_AAS,
      bcd_adj_pkg::CMD_DAA, bcd_adj_pkg::CMD_DAS: begin
        c_next.ax = b_reg.adj_ax;
        c_next.cf = b_reg.adj_cf;
        c_next.af = b_reg.adj_af;
      end
      default: begin
        // unused codes leave everything as it was
        c_next.set_szp = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // stage d: flags of the new al, output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      valid_c   <= valid_b;
      out_valid <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_reg        <= a_next;
      b_reg        <= b_next;
      c_reg        <= c_next;
      ax_out       <= c_reg.ax;
      carry_out    <= c_reg.cf;
      aux_out      <= c_reg.af;
      zero_flag    <= c_reg.set_szp && (c_reg.ax[7:0] == 8'h00);
      sign_flag    <= c_reg.set_szp && c_reg.ax[7];
      parity_flag  <= c_reg.set_szp && !(^c_reg.ax[7:0]);
      divide_error <= c_reg.derr;
    end
  end

`ifndef SYNTH
  // a held result freezes every stage
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(valid_a) && $stable(valid_b) && $stable(valid_c))
    else $error("pipeline moved while output was stalled");

  // partial remainder stays below the divisor in a real aam
  assert property (@(posedge clk) disable iff (rst)
    valid_b && (b_reg.cmd == bcd_adj_pkg::CMD_AAM) && (b_reg.imm != 8'h00)
      |-> b_reg.rem < b_reg.imm)
    else $error("aam partial remainder out of range");

  // divide error carries no meaningful al flags
  assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> !zero_flag && !sign_flag && !parity_flag)
    else $error("flags set alongside divide error");

  // zero flag agrees with the delivered al
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_flag |-> ax_out[7:0] == 8'h00)
    else $error("zero flag with nonzero al");
`endif

endmodule

>>> bench/bcd_adjust_checker.sv
// channel monitor and result predictor for the bcd/ascii adjust unit
`timescale 1ns / 1ps

module bcd_adjust_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [bcd_adj_pkg::CmdWidth-1:0] command,
  input  logic [15:0]                      ax_in,
  input  logic [7:0]                       imm,
  input  logic                             carry_in,
  input  logic                             aux_in,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [15:0]                      ax_out,
  input  logic                             carry_out,
  input  logic                             aux_out,
  input  logic                             zero_flag,
  input  logic                             sign_flag,
  input  logic                             parity_flag,
  input  logic                             divide_error,
  output int                               mismatch_count,
  output int                               pending_count
);

  typedef logic [bcd_adj_pkg::CmdWidth-1:0] cmd_t;

  typedef struct packed {
    logic [15:0] ax;
    logic        cf;
    logic        af;
    logic        zf;
    logic        sf;
    logic        pf;
    logic        de;
  } adjust_result_t;

  typedef struct packed {
    cmd_t           cmd;
    logic [15:0]    ax_before;
    adjust_result_t res;
  } adjust_expect_t;

  adjust_expect_t expected_results[$];

  function automatic adjust_result_t predict_adjust(input cmd_t cmd,
                                                    input logic [15:0] ax,
                                                    input logic [7:0] base,
                                                    input logic cf_in,
                                                    input logic af_in);
    adjust_result_t res;
    logic [7:0]     al;
    logic [7:0]     ah;
    logic [7:0]     old_al;
    logic [15:0]    prod;
    logic           low_adj;
    logic           szp;
    al      = ax[7:0];
    ah      = ax[15:8];
    old_al  = al;
    res.cf  = cf_in;
    res.af  = af_in;
    res.de  = 1'b0;
    szp     = 1'b1;
    low_adj = (al[3:0] > bcd_adj_pkg::DIGIT_MAX) || af_in;
    case (cmd)
      bcd_adj_pkg::CMD_AAA: begin
        if (low_adj) begin
          al = al + bcd_adj_pkg::ADJ_LOW;
          ah = ah + 8'd1;
        end
        res.cf = low_adj;
        res.af = low_adj;
        al     = al & bcd_adj_pkg::NIBBLE_MASK;
      end
      bcd_adj_pkg::CMD_AAS: begin
        if (low_adj) begin
          al = al - bcd_adj_pkg::ADJ_LOW;
          ah = ah - 8'd1;
        end
        res.cf = low_adj;
        res.af = low_adj;
        al     = al & bcd_adj_pkg::NIBBLE_MASK;
      end
      bcd_adj_pkg::CMD_AAM: begin
        // zero base: divide error, registers and flags pass through
        if (base == 8'd0) begin
          res.de = 1'b1;
          szp    = 1'b0;
        end else begin
          ah = al / base;
          al = al % base;
        end
      end
      bcd_adj_pkg::CMD_AAD: begin
        prod = ah * base;
        al   = al + prod[7:0];
        ah   = 8'd0;
      end
      bcd_adj_pkg::CMD_DAA: begin
        if (low_adj) begin
          al     = al + bcd_adj_pkg::ADJ_LOW;
          res.af = 1'b1;
        end else begin
          res.af = 1'b0;
        end
        if (old_al > bcd_adj_pkg::BCD_MAX || cf_in) begin
          al     = al + bcd_adj_pkg::ADJ_HIGH;
          res.cf = 1'b1;
        end else begin
          res.cf = 1'b0;
        end
      end
      bcd_adj_pkg::CMD_DAS: begin
        if (low_adj) begin
          al     = al - bcd_adj_pkg::ADJ_LOW;
          res.af = 1'b1;
        end else begin
          res.af = 1'b0;
        end
        if (old_al > bcd_adj_pkg::BCD_MAX || cf_in) begin
          al     = al - bcd_adj_pkg::ADJ_HIGH;
          res.cf = 1'b1;
        end else begin
          res.cf = 1'b0;
        end
      end
      default: begin
        // unused codes leave everything alone
        szp = 1'b0;
      end
    endcase
    res.ax = {ah, al};
    res.zf = szp && (al == 8'd0);
    res.sf = szp && al[7];
    res.pf = szp && ~^al;
    return res;
  endfunction

  always @(posedge clk) begin
    adjust_expect_t oldest;
    adjust_expect_t incoming;
    adjust_result_t actual;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        actual = {ax_out, carry_out, aux_out, zero_flag, sign_flag, parity_flag,
                  divide_error};
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result transaction: ax=%h cf=%b af=%b", ax_out,
                     carry_out, aux_out);
          mismatch_count <= mismatch_count + 1;
        end else begin
          oldest = expected_results.pop_front();
          if (actual !== oldest.res) begin
            if (mismatch_count < 10)
              $display({"mismatch cmd=%0d ax_in=%h: ",
                        "exp ax=%h cf=%b af=%b zf=%b sf=%b pf=%b de=%b, ",
                        "got ax=%h cf=%b af=%b zf=%b sf=%b pf=%b de=%b"},
                       oldest.cmd, oldest.ax_before, oldest.res.ax, oldest.res.cf,
                       oldest.res.af, oldest.res.zf, oldest.res.sf, oldest.res.pf,
                       oldest.res.de, actual.ax, actual.cf, actual.af, actual.zf,
                       actual.sf, actual.pf, actual.de);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        incoming.cmd       = command;
        incoming.ax_before = ax_in;
        incoming.res       = predict_adjust(command, ax_in, imm, carry_in, aux_in);
        expected_results.push_back(incoming);
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

>>> bench/bcd_ascii_adjust_unit_tb.sv
// stimulus and verdict for the bcd/ascii adjust unit
`timescale 1ns / 1ps

module bcd_ascii_adjust_unit_tb;

  localparam int RandomItems = 1450;
  localparam int HoldCycles  = 60;

  typedef logic [bcd_adj_pkg::CmdWidth-1:0] cmd_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  cmd_t        command;
  logic [15:0] ax_in;
  logic [7:0]  imm;
  logic        carry_in;
  logic        aux_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] ax_out;
  logic        carry_out;
  logic        aux_out;
  logic        zero_flag;
  logic        sign_flag;
  logic        parity_flag;
  logic        divide_error;

  int mismatch_count;
  int pending_count;

  // set by the sender to ask for the long hold-off
  bit hold_request;
  // set by the receiver once that hold-off is over
  bit hold_done;

  bcd_ascii_adjust_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .ax_in        (ax_in),
    .imm          (imm),
    .carry_in     (carry_in),
    .aux_in       (aux_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ax_out       (ax_out),
    .carry_out    (carry_out),
    .aux_out      (aux_out),
    .zero_flag    (zero_flag),
    .sign_flag    (sign_flag),
    .parity_flag  (parity_flag),
    .divide_error (divide_error)
  );

  bcd_adjust_checker adjust_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .ax_in          (ax_in),
    .imm            (imm),
    .carry_in       (carry_in),
    .aux_in         (aux_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ax_out         (ax_out),
    .carry_out      (carry_out),
    .aux_out        (aux_out),
    .zero_flag      (zero_flag),
    .sign_flag      (sign_flag),
    .parity_flag    (parity_flag),
    .divide_error   (divide_error),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50)
      return 0;
    else if (roll < 90)
      return $urandom_range(3, 1);
    else
      return $urandom_range(40, 8);
  endfunction

  // offer one transaction after gap idle cycles and hold it until accepted
  task automatic send_adjust(input cmd_t cmd, input logic [15:0] ax,
                             input logic [7:0] base, input logic cf, input logic af,
                             input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    ax_in    <= ax;
    imm      <= base;
    carry_in <= cf;
    aux_in   <= af;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  // receiver: random ready runs and stalls, plus one long hold-off on request
  initial begin
    int run;
    int gap;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        // long hold-off so the pipeline fills and backs up into in_stall
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= 1'b0;
        // occasionally a long stretch with no stalls at all
        run = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
        repeat (run) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // sender and verdict
  initial begin
    cmd_t cmd;
    bit   quiet;
    int   gap;
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = bcd_adj_pkg::CMD_AAA;
    ax_in        = 16'h0000;
    imm          = 8'h00;
    carry_in     = 1'b0;
    aux_in       = 1'b0;
    hold_request = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // every command code, including the unused ones, at both operand extremes;
    // zero immediate hits the aam divide error
    for (int c = 0; c < 8; c++) begin
      send_adjust(cmd_t'(c), 16'hFFFF, 8'hFF, 1'b1, 1'b1, pick_gap());
      send_adjust(cmd_t'(c), 16'h0000, 8'h00, 1'b0, 1'b0, pick_gap());
    end
    // low nibble just past nine, borrow from ah, high adjust by value alone
    send_adjust(bcd_adj_pkg::CMD_AAA, 16'h00FA, 8'h00, 1'b0, 1'b0, pick_gap());
    send_adjust(bcd_adj_pkg::CMD_AAS, 16'h0000, 8'h00, 1'b0, 1'b1, pick_gap());
    send_adjust(bcd_adj_pkg::CMD_DAA, 16'h129A, 8'h00, 1'b0, 1'b0, pick_gap());
    send_adjust(bcd_adj_pkg::CMD_DAS, 16'h129A, 8'h00, 1'b0, 1'b0, pick_gap());
    send_adjust(bcd_adj_pkg::CMD_AAM, 16'h00FF, 8'h01, 1'b0, 1'b0, pick_gap());
    send_adjust(bcd_adj_pkg::CMD_AAD, 16'hFFFF, 8'hFF, 1'b0, 1'b0, pick_gap());
    drain_results();

    quiet = 1'b0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0)
        quiet = ($urandom_range(2) == 0);
      if (i == 300)
        hold_request = 1'b1;
      if (i == 800)
        drain_results();
      // mostly the six real operations, a few unused codes
      cmd = ($urandom_range(9) == 0) ? cmd_t'($urandom_range(7, 6))
                                     : cmd_t'($urandom_range(5, 0));
      // keep offering back to back while the receiver holds off
      gap = (quiet || (hold_request && !hold_done)) ? 0 : pick_gap();
      send_adjust(cmd, 16'($urandom), ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom),
                  1'($urandom), 1'($urandom), gap);
    end
    drain_results();

    // keep watching to catch any stray result transaction before the verdict
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/bcd_adj_pkg.sv
design/bcd_ascii_adjust_unit.sv
bench/bcd_adjust_checker.sv
bench/bcd_ascii_adjust_unit_tb.sv
